>>> src/afa_pkg.sv
`default_nettype none
package afa_pkg;
    localparam int MAX_REGIONS = 32;
    localparam int IDX_W = $clog2(MAX_REGIONS);
    localparam int CNT_W = IDX_W + 1;
    localparam int DVD_W = 34;

    localparam logic [31:0] CHUNK_RESET = 32'd65536;
    localparam logic [31:0] CAP_LIMIT = 32'hFFFF_FFFF;

    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_RESET = 2'd2;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_ZERO  = 3'd1;
    localparam logic [2:0] ST_NOFIT = 3'd2;
    localparam logic [2:0] ST_INV   = 3'd3;
    localparam logic [2:0] ST_FULL  = 3'd4;
    localparam logic [2:0] ST_CAP   = 3'd5;

    localparam logic [1:0] DIV_SIZE = 2'd0;
    localparam logic [1:0] DIV_PAD  = 2'd1;
    localparam logic [1:0] DIV_GROW = 2'd2;

    typedef struct packed {
        logic       load_item;
        logic       set_status;
        logic [2:0] status;
        logic       div_start;
        logic [1:0] div_sel;
        logic       set_asz;
        logic       scan_clr;
        logic       scan_next;
        logic       set_pad;
        logic       fit_apply;
        logic       set_add;
        logic       ins_init;
        logic       ins_wmode;
        logic       ins_step;
        logic       ins_commit;
        logic       grow_apply;
        logic       free_apply;
        logic       reset_apply;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0]       kind;
        logic             size_zero;
        logic             auto_grow;
        logic             retried;
        logic             free_bad;
        logic             div_done;
        logic             scan_end;
        logic             fits;
        logic             exact;
        logic             cap_over;
        logic             ins_done;
        logic             ins_over;
        logic             out_free;
        logic [CNT_W-1:0] count;
    } t_sts;
endpackage
`default_nettype wire

>>> src/afa_req_if.sv
`default_nettype none
interface afa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] request_size;
    logic [16:0] align;
    logic        auto_grow;
    logic [31:0] region_offset;
    logic [31:0] region_consumed;
    logic [31:0] region_size;
    logic [31:0] capacity_value;

    modport source (
        output valid, kind, request_size, align, auto_grow, region_offset,
               region_consumed, region_size, capacity_value,
        input  ready
    );
    modport sink (
        input  valid, kind, request_size, align, auto_grow, region_offset,
               region_consumed, region_size, capacity_value,
        output ready
    );
endinterface
`default_nettype wire

>>> src/afa_rsp_if.sv
`default_nettype none
interface afa_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] offset_aligned;
    logic [31:0] aligned_size;
    logic [31:0] offset_unpadded;
    logic [31:0] consumed_size;
    logic [16:0] alignment_out;
    logic [31:0] free_total;
    logic [31:0] capacity_total;

    modport source (
        output valid, status, offset_aligned, aligned_size, offset_unpadded,
               consumed_size, alignment_out, free_total, capacity_total,
        input  ready
    );
    modport sink (
        input  valid, status, offset_aligned, aligned_size, offset_unpadded,
               consumed_size, alignment_out, free_total, capacity_total,
        output ready
    );
endinterface
`default_nettype wire

>>> src/afa_div.sv
`default_nettype none
module afa_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [afa_pkg::DVD_W-1:0] i_dividend,
    input  wire logic [31:0]               i_divisor,
    output logic                           o_done,
    output logic [31:0]                    o_rem
);
    logic                      r_busy;
    logic                      r_done;
    logic [5:0]                r_cnt;
    logic [afa_pkg::DVD_W-1:0] r_dvd;
    logic [31:0]               r_dvs;
    logic [31:0]               r_rem;
    logic [32:0]               trial;
    logic                      take;

    assign trial = {r_rem, r_dvd[afa_pkg::DVD_W-1]};
    assign take  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'(afa_pkg::DVD_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == 6'(afa_pkg::DVD_W - 1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    // one quotient bit a cycle; only the remainder is kept
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= 6'd0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= 32'd0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            r_dvd <= {r_dvd[afa_pkg::DVD_W-2:0], 1'b0};
            r_rem <= take ? 32'(trial - {1'b0, r_dvs}) : trial[31:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

>>> src/afa_ctrl.sv
`default_nettype none
module afa_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire afa_pkg::t_sts i_sts,
    output logic               o_ready,
    output afa_pkg::t_cmd      o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_WASZ  = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_WPAD  = 4'd4;
    localparam logic [3:0] S_CHECK = 4'd5;
    localparam logic [3:0] S_MISS  = 4'd6;
    localparam logic [3:0] S_WADD  = 4'd7;
    localparam logic [3:0] S_GROW  = 4'd8;
    localparam logic [3:0] S_CNT   = 4'd9;
    localparam logic [3:0] S_WR    = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                case (i_sts.kind)
                    afa_pkg::KIND_ALLOC: begin
                        if (i_sts.size_zero) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status = afa_pkg::ST_ZERO;
                            n_state = S_FIN;
                        end else begin
                            o_cmd.div_start = 1'b1;
                            o_cmd.div_sel = afa_pkg::DIV_SIZE;
                            n_state = S_WASZ;
                        end
                    end
                    afa_pkg::KIND_FREE: begin
                        if (i_sts.free_bad) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status = afa_pkg::ST_INV;
                            n_state = S_FIN;
                        end else begin
                            o_cmd.ins_init = 1'b1;
                            n_state = S_CNT;
                        end
                    end
                    afa_pkg::KIND_RESET: begin
                        o_cmd.reset_apply = 1'b1;
                        n_state = S_FIN;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_WASZ: begin
                if (i_sts.div_done) begin
                    o_cmd.set_asz = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_end) begin
                    n_state = S_MISS;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel = afa_pkg::DIV_PAD;
                    n_state = S_WPAD;
                end
            end
            S_WPAD: begin
                if (i_sts.div_done) begin
                    o_cmd.set_pad = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.fits) begin
                    o_cmd.fit_apply = 1'b1;
                    n_state = S_FIN;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_MISS: begin
                if (!i_sts.auto_grow || i_sts.retried) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status = afa_pkg::ST_NOFIT;
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel = afa_pkg::DIV_GROW;
                    n_state = S_WADD;
                end
            end
            S_WADD: begin
                if (i_sts.div_done) begin
                    o_cmd.set_add = 1'b1;
                    n_state = S_GROW;
                end
            end
            S_GROW: begin
                if (i_sts.cap_over) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status = afa_pkg::ST_CAP;
                    n_state = S_FIN;
                end else begin
                    o_cmd.ins_init = 1'b1;
                    n_state = S_CNT;
                end
            end
            S_CNT: begin
                if (!i_sts.ins_done) begin
                    o_cmd.ins_step = 1'b1;
                end else if (i_sts.ins_over) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status = afa_pkg::ST_FULL;
                    n_state = S_FIN;
                end else begin
                    o_cmd.ins_init = 1'b1;
                    o_cmd.ins_wmode = 1'b1;
                    n_state = S_WR;
                end
            end
            S_WR: begin
                if (!i_sts.ins_done) begin
                    o_cmd.ins_step = 1'b1;
                end else begin
                    o_cmd.ins_commit = 1'b1;
                    if (i_sts.kind == afa_pkg::KIND_ALLOC) begin
                        o_cmd.grow_apply = 1'b1;
                        o_cmd.scan_clr = 1'b1;
                        n_state = S_SCAN;
                    end else begin
                        o_cmd.free_apply = 1'b1;
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
endmodule
`default_nettype wire

>>> src/afa_dp.sv
`default_nettype none
module afa_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire afa_pkg::t_cmd i_cmd,
    output afa_pkg::t_sts      o_sts,
    input  wire logic          i_cfg_we,
    input  wire logic [31:0]   i_cfg_data,
    input  wire logic [1:0]    i_kind,
    input  wire logic [31:0]   i_request_size,
    input  wire logic [16:0]   i_align,
    input  wire logic          i_auto_grow,
    input  wire logic [31:0]   i_region_offset,
    input  wire logic [31:0]   i_region_consumed,
    input  wire logic [31:0]   i_region_size,
    input  wire logic [31:0]   i_capacity_value,
    input  wire logic          i_rsp_ready,
    output logic               o_rsp_valid,
    output logic [2:0]         o_status,
    output logic [31:0]        o_offset_aligned,
    output logic [31:0]        o_aligned_size,
    output logic [31:0]        o_offset_unpadded,
    output logic [31:0]        o_consumed_size,
    output logic [16:0]        o_alignment_out,
    output logic [31:0]        o_free_total,
    output logic [31:0]        o_capacity_total
);
    localparam int MAXR = afa_pkg::MAX_REGIONS;
    localparam int IW = afa_pkg::IDX_W;
    localparam int CW = afa_pkg::CNT_W;

    logic [31:0] r_start [MAXR];
    logic [31:0] r_len [MAXR];

    logic [CW-1:0] r_count;
    logic [31:0]   r_cap;
    logic [31:0]   r_fb;
    logic [31:0]   r_chunk;
    logic          r_out_v;

    logic [1:0]  r_kind;
    logic [31:0] r_size;
    logic [16:0] r_align;
    logic        r_grow;
    logic [31:0] r_roff;
    logic [31:0] r_rcons;
    logic [31:0] r_rsize;
    logic [31:0] r_capv;
    logic [2:0]  r_status;
    logic        r_retried;
    logic [32:0] r_asz;
    logic [16:0] r_pad;
    logic [33:0] r_total;
    logic [34:0] r_add;
    logic [CW-1:0] r_i;

    logic [31:0] r_res_aligned;
    logic [31:0] r_res_asz;
    logic [31:0] r_res_unp;
    logic [31:0] r_res_cons;
    logic [16:0] r_res_align;

    logic [31:0]   r_ins_s;
    logic [31:0]   r_ins_l;
    logic          r_placed;
    logic          r_acc_v;
    logic [31:0]   r_acc_s;
    logic [38:0]   r_acc_l;
    logic [CW-1:0] r_w;
    logic          r_wmode;

    logic [IW-1:0]             idx;
    logic [31:0]               cur_s;
    logic [31:0]               cur_l;
    logic                      have_tab;
    logic [afa_pkg::DVD_W-1:0] div_dvd;
    logic [31:0]               div_dvs;
    logic                      div_done;
    logic [31:0]               div_rem;
    logic [31:0]               ch;
    logic [33:0]               grow_v;
    logic [32:0]               asz_n;
    logic [16:0]               pad_n;
    logic [34:0]               add_n;
    logic                      take_ins;
    logic                      e_valid;
    logic [31:0]               e_s;
    logic [31:0]               e_l;
    logic                      merge;

    assign idx      = r_i[IW-1:0];
    assign cur_s    = r_start[idx];
    assign cur_l    = r_len[idx];
    assign have_tab = r_i < r_count;
    assign ch       = (r_chunk == 32'd0) ? 32'd1 : r_chunk;
    assign grow_v   = 34'(r_asz) + 34'(r_align) - 34'd1;

    always_comb begin
        case (i_cmd.div_sel)
            afa_pkg::DIV_SIZE: begin
                div_dvd = afa_pkg::DVD_W'(r_size);
                div_dvs = 32'(r_align);
            end
            afa_pkg::DIV_PAD: begin
                div_dvd = afa_pkg::DVD_W'(cur_s);
                div_dvs = 32'(r_align);
            end
            default: begin
                div_dvd = grow_v;
                div_dvs = ch;
            end
        endcase
    end

    afa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // round up = value + divisor - remainder when the remainder is nonzero
    assign asz_n = (div_rem == 32'd0) ? 33'(r_size)
                 : 33'(r_size) + 33'(r_align) - 33'(div_rem);
    assign pad_n = (div_rem == 32'd0) ? 17'd0 : r_align - div_rem[16:0];
    assign add_n = (div_rem == 32'd0) ? 35'(grow_v)
                 : 35'(grow_v) + 35'(ch) - 35'(div_rem);

    // merge stream: the new range slots in before the first larger start
    assign take_ins = !r_placed && (!have_tab || (cur_s > r_ins_s));
    assign e_valid  = have_tab || !r_placed;
    assign e_s      = take_ins ? r_ins_s : cur_s;
    assign e_l      = take_ins ? r_ins_l : cur_l;
    assign merge    = r_acc_v && ((40'(r_acc_s) + 40'(r_acc_l)) == 40'(e_s));

    always_comb begin
        o_sts.kind      = r_kind;
        o_sts.size_zero = (r_size == 32'd0);
        o_sts.auto_grow = r_grow;
        o_sts.retried   = r_retried;
        o_sts.free_bad  = (r_rsize == 32'd0) || ((33'(r_roff) + 33'(r_rcons)) > 33'(r_cap));
        o_sts.div_done  = div_done;
        o_sts.scan_end  = !have_tab;
        o_sts.fits      = r_total <= 34'(cur_l);
        o_sts.exact     = r_total == 34'(cur_l);
        o_sts.cap_over  = (r_add > 35'(afa_pkg::CAP_LIMIT))
                       || ((35'(r_cap) + r_add) > 35'(afa_pkg::CAP_LIMIT));
        o_sts.ins_done  = !e_valid;
        o_sts.ins_over  = r_w >= CW'(MAXR);
        o_sts.out_free  = !r_out_v || i_rsp_ready;
        o_sts.count     = r_count;
    end

    // free table
    always_ff @(posedge i_clk) begin
        if (i_cmd.reset_apply) begin
            r_start[0] <= 32'd0;
            r_len[0]   <= r_capv;
        end else if (i_cmd.fit_apply) begin
            if (r_total == 34'(cur_l)) begin
                for (int j = 0; j < MAXR - 1; j++) begin
                    if (CW'(j) >= r_i) begin
                        r_start[j] <= r_start[j + 1];
                        r_len[j]   <= r_len[j + 1];
                    end
                end
            end else begin
                r_start[idx] <= cur_s + r_total[31:0];
                r_len[idx]   <= cur_l - r_total[31:0];
            end
        end else if (r_wmode && r_acc_v && ((i_cmd.ins_step && e_valid && !merge)
                                            || i_cmd.ins_commit)) begin
            r_start[r_w[IW-1:0]] <= r_acc_s;
            r_len[r_w[IW-1:0]]   <= r_acc_l[31:0];
        end
    end

    // arena state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cap   <= 32'd0;
            r_fb    <= 32'd0;
            r_chunk <= afa_pkg::CHUNK_RESET;
            r_out_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_chunk <= i_cfg_data;
            end
            if (i_cmd.reset_apply) begin
                r_count <= CW'(1);
                r_cap   <= r_capv;
                r_fb    <= r_capv;
            end
            if (i_cmd.fit_apply) begin
                r_fb <= r_fb - r_total[31:0];
                if (r_total == 34'(cur_l)) begin
                    r_count <= r_count - CW'(1);
                end
            end
            if (i_cmd.ins_commit && r_wmode) begin
                r_count <= r_w + CW'(1);
            end
            if (i_cmd.grow_apply) begin
                r_cap <= r_cap + r_add[31:0];
                r_fb  <= r_fb + r_add[31:0];
            end
            if (i_cmd.free_apply) begin
                r_fb <= r_fb + r_rcons;
            end
            if (i_cmd.out_load) begin
                r_out_v <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // item working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_kind        <= i_kind;
            r_size        <= i_request_size;
            r_align       <= (i_align == 17'd0) ? 17'd1 : i_align;
            r_grow        <= i_auto_grow;
            r_roff        <= i_region_offset;
            r_rcons       <= i_region_consumed;
            r_rsize       <= i_region_size;
            r_capv        <= i_capacity_value;
            r_status      <= afa_pkg::ST_OK;
            r_retried     <= 1'b0;
            r_res_aligned <= 32'd0;
            r_res_asz     <= 32'd0;
            r_res_unp     <= 32'd0;
            r_res_cons    <= 32'd0;
            r_res_align   <= 17'd0;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.set_asz) begin
            r_asz <= asz_n;
        end
        if (i_cmd.set_pad) begin
            r_pad   <= pad_n;
            r_total <= 34'(r_asz) + 34'(pad_n);
        end
        if (i_cmd.set_add) begin
            r_add <= add_n;
        end
        if (i_cmd.grow_apply) begin
            r_retried <= 1'b1;
        end
        if (i_cmd.fit_apply) begin
            r_res_aligned <= cur_s + 32'(r_pad);
            r_res_asz     <= r_asz[31:0];
            r_res_unp     <= cur_s;
            r_res_cons    <= r_total[31:0];
            r_res_align   <= r_align;
        end
        if (i_cmd.scan_clr) begin
            r_i <= '0;
        end else if (i_cmd.scan_next) begin
            r_i <= r_i + CW'(1);
        end else if (i_cmd.ins_init) begin
            r_i      <= '0;
            r_placed <= 1'b0;
            r_acc_v  <= 1'b0;
            r_w      <= '0;
            r_wmode  <= i_cmd.ins_wmode;
            if (r_kind == afa_pkg::KIND_ALLOC) begin
                r_ins_s <= r_cap;
                r_ins_l <= r_add[31:0];
            end else begin
                r_ins_s <= r_roff;
                r_ins_l <= r_rcons;
            end
        end else if (i_cmd.ins_step && e_valid) begin
            if (take_ins) begin
                r_placed <= 1'b1;
            end else begin
                r_i <= r_i + CW'(1);
            end
            if (merge) begin
                r_acc_l <= r_acc_l + 39'(e_l);
            end else begin
                r_acc_s <= e_s;
                r_acc_l <= 39'(e_l);
                r_acc_v <= 1'b1;
                if (r_acc_v) begin
                    r_w <= r_w + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status          <= r_status;
            o_offset_aligned  <= r_res_aligned;
            o_aligned_size    <= r_res_asz;
            o_offset_unpadded <= r_res_unp;
            o_consumed_size   <= r_res_cons;
            o_alignment_out   <= r_res_align;
            o_free_total      <= r_fb;
            o_capacity_total  <= r_cap;
        end
    end

    assign o_rsp_valid = r_out_v;
endmodule
`default_nettype wire

>>> src/aligned_first_fit_allocator_unit.sv
// Allocate: one division for the size, then one per free range scanned until a fit;
//   a growth adds a division, a count pass and a write pass, then a rescan; free runs both passes.
// Throughput: one item at a time, each division 34 steps of the shared remainder divider;
//   the next item is taken the cycle after the result register loads.
// One result register: the next item is taken while a result waits.
// Reset (synchronous, i_rst_n low): empty table, capacity and free bytes zero, chunk 65536.
`default_nettype none
module aligned_first_fit_allocator_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_data,
    afa_req_if.sink          i_req,
    afa_rsp_if.source        o_rsp
);
    afa_pkg::t_cmd w_cmd;
    afa_pkg::t_sts w_sts;
    logic          w_ready;

    // sequencer: decode, scan, grow, merge passes
    afa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .i_sts   (w_sts),
        .o_ready (w_ready),
        .o_cmd   (w_cmd)
    );

    assign i_req.ready = w_ready;

    // table, divider, arena counters, result register
    afa_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_kind            (i_req.kind),
        .i_request_size    (i_req.request_size),
        .i_align           (i_req.align),
        .i_auto_grow       (i_req.auto_grow),
        .i_region_offset   (i_req.region_offset),
        .i_region_consumed (i_req.region_consumed),
        .i_region_size     (i_req.region_size),
        .i_capacity_value  (i_req.capacity_value),
        .i_rsp_ready       (o_rsp.ready),
        .o_rsp_valid       (o_rsp.valid),
        .o_status          (o_rsp.status),
        .o_offset_aligned  (o_rsp.offset_aligned),
        .o_aligned_size    (o_rsp.aligned_size),
        .o_offset_unpadded (o_rsp.offset_unpadded),
        .o_consumed_size   (o_rsp.consumed_size),
        .o_alignment_out   (o_rsp.alignment_out),
        .o_free_total      (o_rsp.free_total),
        .o_capacity_total  (o_rsp.capacity_total)
    );

    // table never holds more ranges than it has rows
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.count <= afa_pkg::CNT_W'(afa_pkg::MAX_REGIONS))
        else $error("range count above table depth");

    // an accepted item closes the input until its result is queued
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("second item taken while busy");

    // a result appears only from a load by the sequencer
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(w_cmd.out_load))
        else $error("result valid without load");

    // a range is taken only when it was found to fit
    a_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.fit_apply |-> (w_sts.fits && !w_sts.scan_end))
        else $error("allocation from a range that does not fit");
endmodule
`default_nettype wire
